/* hw/rtl/sec_pkg.sv */
package sec_pkg;

  // Range allowed for the next continuation byte.
  typedef enum logic [2:0] {
    RANGE_80_BF = 3'd0,
    RANGE_A0_BF = 3'd1,
    RANGE_80_9F = 3'd2,
    RANGE_90_BF = 3'd3,
    RANGE_80_8F = 3'd4
  } range_t;

  typedef struct packed {
    logic [1:0] cont_left;
    range_t     next_range;
    logic       string_bad;
  } sec_state_t;

  localparam sec_state_t STATE_CLEAR = '{cont_left: 2'd0, next_range: RANGE_80_BF,
                                         string_bad: 1'b0};

endpackage

/* hw/rtl/sec_step.sv */
module sec_step (
  input  logic [7:0]         data_byte,
  input  logic               has_byte,
  input  logic               last,
  input  logic               mode,
  input  logic               check_enabled,
  input  sec_pkg::sec_state_t state,
  output sec_pkg::sec_state_t state_next,
  output logic               string_ok
);
  import sec_pkg::*;

  logic       cont_ok;
  sec_state_t upd;

  always_comb begin
    case (state.next_range)
      RANGE_A0_BF: cont_ok = (data_byte >= 8'hA0) && (data_byte <= 8'hBF);
      RANGE_80_9F: cont_ok = (data_byte >= 8'h80) && (data_byte <= 8'h9F);
      RANGE_90_BF: cont_ok = (data_byte >= 8'h90) && (data_byte <= 8'hBF);
      RANGE_80_8F: cont_ok = (data_byte >= 8'h80) && (data_byte <= 8'h8F);
      default:     cont_ok = (data_byte[7:6] == 2'b10);
    endcase
  end

  always_comb begin
    upd = state;
    if (has_byte) begin
      if (!mode) begin
        if (data_byte[7]) begin
          upd.string_bad = 1'b1;
        end
      end else if (state.cont_left != 2'd0) begin
        // A failed continuation byte still counts against the sequence.
        if (!cont_ok) begin
          upd.string_bad = 1'b1;
        end
        upd.cont_left  = state.cont_left - 2'd1;
        upd.next_range = RANGE_80_BF;
      end else begin
        upd.next_range = RANGE_80_BF;
        if (!data_byte[7]) begin
          upd.cont_left = 2'd0;
        end else if (data_byte[7:5] == 3'b110) begin
          // C0 and C1 can only start overlong forms.
          if (data_byte[7:1] == 7'b1100000) begin
            upd.string_bad = 1'b1;
          end else begin
            upd.cont_left = 2'd1;
          end
        end else if (data_byte[7:4] == 4'b1110) begin
          upd.cont_left = 2'd2;
          if (data_byte == 8'hE0) begin
            upd.next_range = RANGE_A0_BF;
          end else if (data_byte == 8'hED) begin
            upd.next_range = RANGE_80_9F;
          end
        end else if (data_byte[7:3] == 5'b11110) begin
          if (data_byte > 8'hF4) begin
            upd.string_bad = 1'b1;
          end else begin
            upd.cont_left = 2'd3;
            if (data_byte == 8'hF0) begin
              upd.next_range = RANGE_90_BF;
            end else if (data_byte == 8'hF4) begin
              upd.next_range = RANGE_80_8F;
            end
          end
        end else begin
          upd.string_bad = 1'b1;
        end
      end
    end
  end

  assign string_ok  = !check_enabled ||
                      (!upd.string_bad && !(mode && (upd.cont_left != 2'd0)));
  assign state_next = last ? STATE_CLEAR : upd;

endmodule

/* hw/rtl/string_encoding_checker.sv */
// Pipeline: an accepted byte beat is captured in the input register and checked there by
// sec_step; a string's last beat writes its result to the output register behind m_tvalid.
// Throughput: one byte per cycle; the only loop is the state register's update through sec_step.
// A finished result waiting in the output register stalls only a further last beat.
// Reset clears the pipeline valids and the checker state and sets check_enabled to 1.
module string_encoding_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic [1:0] s_tuser,   // [0] has_byte, [1] mode
  input  logic       s_tlast,   // last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [0] string_ok, [7:1] zero
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data   // check_enabled
);
  import sec_pkg::*;

  logic       check_enabled;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_has;
  logic       in_mode;
  logic       in_last;
  sec_state_t state;
  sec_state_t state_next;
  logic       ok_next;
  logic       out_valid;
  logic       out_ok;
  logic       out_free;
  logic       step;

  assign out_free  = !out_valid || m_tready;
  // Only a last beat needs room in the output register.
  assign step      = in_valid && (!in_last || out_free);
  assign s_tready  = !in_valid || step;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {7'd0, out_ok};

  always_ff @(posedge clk) begin
    if (rst) begin
      check_enabled <= 1'b1;
    end else if (cfg_valid) begin
      check_enabled <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_has  <= s_tuser[0];
      in_mode <= s_tuser[1];
      in_last <= s_tlast;
    end
  end

  sec_step u_step (
    .data_byte     (in_byte),
    .has_byte      (in_has),
    .last          (in_last),
    .mode          (in_mode),
    .check_enabled (check_enabled),
    .state         (state),
    .state_next    (state_next),
    .string_ok     (ok_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (step) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      out_ok <= ok_next;
    end
  end

  a_three_byte_range: assert property (@(posedge clk) disable iff (rst)
    (state.next_range == RANGE_A0_BF || state.next_range == RANGE_80_9F)
      |-> state.cont_left == 2'd2)
    else $error("E0/ED range pending without two continuation bytes");

  a_four_byte_range: assert property (@(posedge clk) disable iff (rst)
    (state.next_range == RANGE_90_BF || state.next_range == RANGE_80_8F)
      |-> state.cont_left == 2'd3)
    else $error("F0/F4 range pending without three continuation bytes");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (step && in_last) |=> (state == STATE_CLEAR && out_valid))
    else $error("state not cleared or result missing after a last beat");

  a_disabled_passes: assert property (@(posedge clk) disable iff (rst)
    (step && in_last && !check_enabled) |=> out_ok)
    else $error("string failed while checking was disabled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> (out_valid && $stable(out_ok)))
    else $error("pending result lost or changed");

endmodule

/* sim/sec_verdict_monitor.sv */
`timescale 1ns / 100ps

module sec_verdict_monitor (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic [1:0] s_tuser,   // [0] has_byte, [1] mode
  input  logic       s_tlast,   // last
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [0] string_ok, [7:1] zero
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_data,  // check_enabled
  output int         fail_count,
  output int         verdicts_owed
);
  import sec_pkg::*;

  logic [1:0] seq_left;
  range_t     cont_range;
  logic       seen_error;
  logic       check_en;
  logic       verdict_q[$];
  int         fails = 0;

  always @(posedge clk) begin : track
    logic [7:0] b;
    logic       utf8;
    logic       fits;
    logic       ok;
    logic       want;
    if (rst) begin
      seq_left   = 2'd0;
      cont_range = RANGE_80_BF;
      seen_error = 1'b0;
      check_en   = 1'b1;
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) check_en = cfg_data;

      // A result leaves only after its last beat has passed the input and output
      // registers, so compare before anything accepted at this edge is added.
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          $error("string_ok: expected nothing, actual %0b", m_tdata[0]);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[0] !== want) begin
            $error("string_ok: expected %0b, actual %0b", want, m_tdata[0]);
            fails++;
          end
        end
        if (m_tdata[7:1] !== 7'd0) begin
          $error("m_tdata padding: expected 0, actual %0h", m_tdata[7:1]);
          fails++;
        end
      end

      if (s_tvalid && s_tready) begin
        b    = s_tdata;
        utf8 = s_tuser[1];
        if (s_tuser[0]) begin
          if (!utf8) begin
            if (b[7]) seen_error = 1'b1;
          end else if (seq_left != 2'd0) begin
            case (cont_range)
              RANGE_A0_BF: fits = (b >= 8'hA0) && (b <= 8'hBF);
              RANGE_80_9F: fits = (b >= 8'h80) && (b <= 8'h9F);
              RANGE_90_BF: fits = (b >= 8'h90) && (b <= 8'hBF);
              RANGE_80_8F: fits = (b >= 8'h80) && (b <= 8'h8F);
              default:     fits = (b[7:6] == 2'b10);
            endcase
            // A bad continuation byte still uses up its place in the sequence.
            if (!fits) seen_error = 1'b1;
            seq_left   = seq_left - 2'd1;
            cont_range = RANGE_80_BF;
          end else begin
            cont_range = RANGE_80_BF;
            if (b[7:5] == 3'b110) begin
              // C0 and C1 could only give overlong two-byte forms.
              if (b[7:1] == 7'b1100000) seen_error = 1'b1;
              else seq_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
              seq_left = 2'd2;
              if (b == 8'hE0) cont_range = RANGE_A0_BF;
              else if (b == 8'hED) cont_range = RANGE_80_9F;
            end else if (b[7:3] == 5'b11110) begin
              if (b > 8'hF4) begin
                seen_error = 1'b1;
              end else begin
                seq_left = 2'd3;
                if (b == 8'hF0) cont_range = RANGE_90_BF;
                else if (b == 8'hF4) cont_range = RANGE_80_8F;
              end
            end else if (b[7]) begin
              seen_error = 1'b1;
            end
          end
        end
        if (s_tlast) begin
          ok = !seen_error && !(utf8 && seq_left != 2'd0);
          verdict_q.push_back(ok || !check_en);
          seq_left   = 2'd0;
          cont_range = RANGE_80_BF;
          seen_error = 1'b0;
        end
      end
    end
    fail_count    <= fails;
    verdicts_owed <= verdict_q.size();
  end

endmodule

/* sim/tb_string_encoding_checker.sv */
`timescale 1ns / 100ps

module tb_string_encoding_checker;

  localparam int HOLD_CYCLES = 300;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       s_tvalid  = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata   = 8'd0;   // [7:0] data_byte
  logic [1:0] s_tuser   = 2'd0;   // [0] has_byte, [1] mode
  logic       s_tlast   = 1'b0;
  logic       m_tvalid;
  logic       m_tready  = 1'b0;
  logic [7:0] m_tdata;            // [0] string_ok, [7:1] zero
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data  = 1'b0;

  int   fail_count;
  int   verdicts_owed;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   n_beats   = 0;
  int   n_strings = 0;
  int   n_utf8    = 0;

  always #1 clk = ~clk;

  string_encoding_checker i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  sec_verdict_monitor i_verdicts (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .verdicts_owed(verdicts_owed)
  );

  // Result side: random stalls, plus one long hold-off so that the block backs up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_beat(input logic [7:0] b, input logic has, input logic last,
                           input logic utf8);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom_range(255));
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {utf8, has};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (has || last) n_beats++;
    if (last) begin
      n_strings++;
      if (utf8) n_utf8++;
    end
  endtask

  task automatic write_check_enable(input logic en);
    s_tvalid <= 1'b0;
    // The monitor's count of owed verdicts is registered, so it lags the last beat.
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Second byte after a lead; the special leads narrow the legal range.
  function automatic logic [7:0] second_byte(input logic [7:0] lead);
    logic legal;
    legal = ($urandom_range(19) != 0);
    case (lead)
      8'hE0:   return legal ? 8'($urandom_range(8'hBF, 8'hA0)) : 8'($urandom_range(8'h9F, 8'h80));
      8'hED:   return legal ? 8'($urandom_range(8'h9F, 8'h80)) : 8'($urandom_range(8'hBF, 8'hA0));
      8'hF0:   return legal ? 8'($urandom_range(8'hBF, 8'h90)) : 8'($urandom_range(8'h8F, 8'h80));
      8'hF4:   return legal ? 8'($urandom_range(8'h8F, 8'h80)) : 8'($urandom_range(8'hBF, 8'h90));
      default: return legal ? 8'($urandom_range(8'hBF, 8'h80)) : 8'($urandom_range(8'hFF, 8'hC0));
    endcase
  endfunction

  task automatic send_random_string();
    logic [7:0] text[$];
    logic [7:0] lead;
    logic       utf8;
    int         nchar;
    int         pos;
    utf8  = ($urandom_range(99) < 75);
    nchar = ($urandom_range(99) < 5) ? 0 : $urandom_range(5, 1);
    for (int c = 0; c < nchar; c++) begin
      if (!utf8) begin
        text.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(127)));
      end else begin
        case ($urandom_range(3))
          0: text.push_back(8'($urandom_range(127)));
          1: begin
            text.push_back(8'($urandom_range(8'hDF, 8'hC2)));
            text.push_back(8'($urandom_range(8'hBF, 8'h80)));
          end
          2: begin
            lead = $urandom_range(1) ? ($urandom_range(1) ? 8'hE0 : 8'hED)
                                     : 8'($urandom_range(8'hEF, 8'hE0));
            text.push_back(lead);
            text.push_back(second_byte(lead));
            text.push_back(8'($urandom_range(8'hBF, 8'h80)));
          end
          default: begin
            lead = $urandom_range(1) ? ($urandom_range(1) ? 8'hF0 : 8'hF4)
                                     : 8'($urandom_range(8'hF4, 8'hF0));
            text.push_back(lead);
            text.push_back(second_byte(lead));
            text.push_back(8'($urandom_range(8'hBF, 8'h80)));
            text.push_back(8'($urandom_range(8'hBF, 8'h80)));
          end
        endcase
      end
    end

    // Now and then spoil one byte with a bad lead, a stray continuation or noise.
    if (text.size() != 0 && $urandom_range(9) == 0) begin
      pos = $urandom_range(text.size() - 1);
      case ($urandom_range(3))
        0:       text[pos] = 8'($urandom_range(8'hC1, 8'hC0));
        1:       text[pos] = 8'($urandom_range(8'hFF, 8'hF5));
        2:       text[pos] = 8'($urandom_range(8'hBF, 8'h80));
        default: text[pos] = 8'($urandom_range(255));
      endcase
    end
    // Cut a sequence short at the end of the string.
    if (utf8 && text.size() != 0 && $urandom_range(11) == 0 &&
        text[text.size() - 1][7:6] == 2'b10)
      text.pop_back();

    if (text.size() == 0) push_beat(8'($urandom_range(255)), 1'b0, 1'b1, utf8);
    foreach (text[i]) begin
      if ($urandom_range(24) == 0) push_beat(8'($urandom_range(255)), 1'b0, 1'b0, utf8);
      push_beat(text[i], 1'b1, i == text.size() - 1,
                ($urandom_range(39) == 0) ? !utf8 : utf8);
    end
  endtask

  task automatic run_random(input int beats);
    int goal;
    goal = n_beats + beats;
    while (n_beats < goal) send_random_string();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed strings, checking on from reset.
    push_beat(8'h00, 1'b0, 1'b1, 1'b1);   // empty string
    push_beat(8'h7F, 1'b1, 1'b0, 1'b0);   // ASCII top value, then a high byte
    push_beat(8'h80, 1'b1, 1'b1, 1'b0);
    push_beat(8'h00, 1'b1, 1'b1, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0, 1'b1);   // idle step, no byte
    push_beat(8'hC1, 1'b1, 1'b1, 1'b1);   // overlong two-byte lead
    push_beat(8'hE0, 1'b1, 1'b0, 1'b1);   // overlong three-byte form
    push_beat(8'h9F, 1'b1, 1'b0, 1'b1);
    push_beat(8'h80, 1'b1, 1'b1, 1'b1);
    push_beat(8'hED, 1'b1, 1'b0, 1'b1);   // surrogate
    push_beat(8'hA0, 1'b1, 1'b0, 1'b1);
    push_beat(8'h80, 1'b1, 1'b1, 1'b1);
    push_beat(8'hF4, 1'b1, 1'b0, 1'b1);   // just above U+10FFFF
    push_beat(8'h90, 1'b1, 1'b0, 1'b1);
    push_beat(8'h80, 1'b1, 1'b0, 1'b1);
    push_beat(8'h80, 1'b1, 1'b1, 1'b1);
    push_beat(8'hF0, 1'b1, 1'b0, 1'b1);   // legal four-byte form, lowest lead and second byte
    push_beat(8'h90, 1'b1, 1'b0, 1'b1);
    push_beat(8'h80, 1'b1, 1'b0, 1'b1);
    push_beat(8'hBF, 1'b1, 1'b1, 1'b1);
    push_beat(8'hE2, 1'b1, 1'b0, 1'b1);   // truncated sequence
    push_beat(8'h82, 1'b1, 1'b1, 1'b1);
    push_beat(8'hC3, 1'b1, 1'b0, 1'b1);   // mode switched to ASCII mid-sequence
    push_beat(8'h41, 1'b1, 1'b1, 1'b0);
    push_beat(8'hFF, 1'b1, 1'b1, 1'b1);   // never a valid lead

    write_check_enable(1'b0);
    idle_pct  = 16;
    stall_pct = 71;
    run_random(200);

    write_check_enable(1'b1);
    run_random(600);

    idle_pct  = 71;
    stall_pct = 16;
    run_random(600);

    idle_pct  = 0;
    stall_pct = 0;
    hold_req <= 1'b1;
    run_random(600);
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d strings (%0d finished in UTF-8 mode) from %0d beats,",
             n_strings, n_utf8, n_beats);
    $display("with checking off and on, gaps on both sides and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("string_encoding_checker test passed");
    end else begin
      $display("string_encoding_checker test failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("string_encoding_checker test failed");
    $finish;
  end

endmodule
